// ===== src/lcis_pkg.sv =====
// Shared types, constants and step functions for the line and circle intersection pipeline.
package lcis_pkg;

	localparam int DIV_QW = 36;
	localparam int DIV_W = 100;
	localparam int SQ_W = 129;
	localparam int PT_W = 38;
	localparam logic [34:0] OFS_LIMIT = 35'h4_0000_0000;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_QW-1:0] q;
		logic ovf;
	} qdiv_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [63:0] res;
	} sqst_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic [30:0] r;
		logic near;
		logic [63:0] aa;
		logic [63:0] bb;
		logic signed [63:0] acx;
		logic signed [63:0] bcy;
		logic signed [63:0] ct;
		logic [61:0] rr;
		logic [63:0] den;
		logic [63:0] smag;
		logic sneg;
		logic degen;
		logic nohit;
		logic [63:0] rp0;
		logic [63:0] rp1;
		logic [63:0] rp2;
		logic [63:0] rp3;
		logic [63:0] sp0;
		logic [63:0] sp1;
		logic [63:0] sp2;
		logic [63:0] ap0;
		logic [63:0] ap1;
		logic [63:0] bp0;
		logic [63:0] bp1;
		logic [127:0] rd;
		logic [127:0] s2;
		logic [95:0] na;
		logic [95:0] nb;
		sqst_t sq;
		qdiv_t fx;
		qdiv_t fy;
		qdiv_t hx;
		qdiv_t hy;
		logic signed [PT_W-1:0] x0;
		logic signed [PT_W-1:0] y0;
		logic signed [PT_W-1:0] x1;
		logic signed [PT_W-1:0] y1;
		logic signed [PT_W-1:0] x2;
		logic signed [PT_W-1:0] y2;
		logic [75:0] q1x;
		logic [75:0] q1y;
		logic [75:0] q2x;
		logic [75:0] q2y;
		logic [76:0] d1;
		logic [76:0] d2;
	} pl_t;

	function automatic logic [31:0] mag32(logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// The quotient is only needed up to the offset clamp, so overflow past 36 bits is a flag.
	function automatic qdiv_t div_init(logic [95:0] n, logic [63:0] d);
		qdiv_t y;
		y.rem = {4'b0, n};
		y.q = '0;
		y.ovf = ({4'b0, n} >= {d, 36'b0});
		return y;
	endfunction

	function automatic qdiv_t div_step(qdiv_t x, logic [63:0] d, int j);
		qdiv_t y;
		logic [DIV_W-1:0] sub;
		y = x;
		sub = {36'b0, d} << j;
		if (x.rem >= sub) begin
			y.rem = x.rem - sub;
			y.q = x.q | (DIV_QW'(1) << j);
		end
		return y;
	endfunction

	function automatic logic signed [35:0] div_out(qdiv_t x, logic neg);
		logic [34:0] v;
		v = (x.ovf || x.q > {1'b0, OFS_LIMIT}) ? OFS_LIMIT : x.q[34:0];
		return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
	endfunction

	// Restoring square root: (res + 2^i)^2 - res^2 = res*2^(i+1) + 2^(2i).
	function automatic sqst_t sqrt_step(sqst_t x, int i);
		sqst_t y;
		logic [SQ_W-1:0] t;
		y = x;
		t = ({65'b0, x.res} << (i + 1)) | (SQ_W'(1) << (2 * i));
		if (x.rem >= t) begin
			y.rem = x.rem - t;
			y.res = x.res | (64'(1) << i);
		end
		return y;
	endfunction

	function automatic logic [31:0] sat32(logic signed [PT_W-1:0] v);
		if (v > 38'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (v < -38'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// ===== src/line_circle_intersection_select.sv =====
// Line and circle intersection selector: a 112-stage pipeline with one query per beat.
// Each query enters the pipeline in the beat it is accepted, and a new query can be accepted in every
// cycle while the pipeline is not held. The depth comes mostly from two parts. The first is the 64-stage
// square root of the squared half chord, which runs beside the two foot-point dividers. The second is
// the 36-stage pair of chord-offset dividers, which resolve one quotient bit per stage. The whole
// pipeline advances together. It holds only while a finished result waits at the output and out_stall
// is high, and in_stall is high exactly then.
module line_circle_intersection_select
	import lcis_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] line_a,
	input  logic signed [31:0] line_b,
	input  logic signed [31:0] line_c,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic [30:0]        circle_radius,
	input  logic signed [31:0] ref_x,
	input  logic signed [31:0] ref_y,
	input  logic               prefer_near,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic               intersects,
	output logic               degenerate_line
);

	localparam int NST = 112;
	localparam int SQ_N = 64;
	localparam int CH_N = DIV_QW;

	logic adv;
	logic [NST-1:0] vld_s;

	pl_t n1, p_s1, n2, p_s2, n3, p_s3, n4, p_s4, n5, p_s5;
	pl_t p_sq_s [SQ_N];
	pl_t n6, p_s6, n7, p_s7, n8, p_s8;
	pl_t p_ch_s [CH_N];
	pl_t n9, p_s9, n10, p_s10, n11, p_s11;

	logic signed [65:0] ssum;
	logic [31:0] ma3, mb3, ma6, mb6;
	logic signed [35:0] fox, foy, ox9, oy9;
	logic signed [PT_W:0] e1x, e1y, e2x, e2y;
	logic [PT_W-1:0] m1x, m1y, m2x, m2y;
	logic first_nearer, pick1;
	logic signed [PT_W-1:0] selx, sely;
	logic [31:0] ox_n, oy_n;
	logic hit_n, deg_n;
	logic [31:0] x_s12, y_s12;
	logic hit_s12, deg_s12;

	assign adv = !(vld_s[NST-1] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_s[NST-1];
	assign point_x = x_s12;
	assign point_y = y_s12;
	assign intersects = hit_s12;
	assign degenerate_line = deg_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	// Stage 1: the narrow products.
	always_comb begin
		n1 = p_s1;
		n1.a = line_a;
		n1.b = line_b;
		n1.cx = center_x;
		n1.cy = center_y;
		n1.rx = ref_x;
		n1.ry = ref_y;
		n1.r = circle_radius;
		n1.near = prefer_near;
		n1.aa = line_a * line_a;
		n1.bb = line_b * line_b;
		n1.acx = line_a * center_x;
		n1.bcy = line_b * center_y;
		n1.ct = $signed({{32{line_c[31]}}, line_c}) <<< FRAC_BITS;
		n1.rr = circle_radius * circle_radius;
	end

	// Stage 2: the line norm and the signed distance term.
	always_comb begin
		n2 = p_s1;
		ssum = 66'(p_s1.acx) + 66'(p_s1.bcy) + 66'(p_s1.ct);
		n2.den = p_s1.aa + p_s1.bb;
		n2.sneg = ssum[65];
		n2.smag = ssum[65] ? 64'(-ssum) : 64'(ssum);
		n2.degen = (p_s1.aa + p_s1.bb) == 64'd0;
	end

	// Stage 3: the wide products, split into 32 by 32 partial products.
	always_comb begin
		n3 = p_s2;
		ma3 = mag32(p_s2.a);
		mb3 = mag32(p_s2.b);
		n3.rp0 = p_s2.rr[31:0] * p_s2.den[31:0];
		n3.rp1 = p_s2.rr[31:0] * p_s2.den[63:32];
		n3.rp2 = {2'b0, p_s2.rr[61:32]} * p_s2.den[31:0];
		n3.rp3 = {2'b0, p_s2.rr[61:32]} * p_s2.den[63:32];
		n3.sp0 = p_s2.smag[31:0] * p_s2.smag[31:0];
		n3.sp1 = p_s2.smag[31:0] * p_s2.smag[63:32];
		n3.sp2 = p_s2.smag[63:32] * p_s2.smag[63:32];
		n3.ap0 = ma3 * p_s2.smag[31:0];
		n3.ap1 = ma3 * p_s2.smag[63:32];
		n3.bp0 = mb3 * p_s2.smag[31:0];
		n3.bp1 = mb3 * p_s2.smag[63:32];
	end

	// Stage 4: sum the partial products.
	always_comb begin
		n4 = p_s3;
		n4.rd = {64'b0, p_s3.rp0} + ({64'b0, p_s3.rp1} << 32) + ({64'b0, p_s3.rp2} << 32)
			+ {p_s3.rp3, 64'b0};
		n4.s2 = {64'b0, p_s3.sp0} + ({64'b0, p_s3.sp1} << 33) + {p_s3.sp2, 64'b0};
		n4.na = {32'b0, p_s3.ap0} + {p_s3.ap1, 32'b0};
		n4.nb = {32'b0, p_s3.bp0} + {p_s3.bp1, 32'b0};
	end

	// Stage 5: the miss test, the radicand and the divider set-up.
	always_comb begin
		n5 = p_s4;
		n5.nohit = p_s4.s2 > p_s4.rd;
		n5.sq.rem = {1'b0, p_s4.rd - p_s4.s2};
		n5.sq.res = '0;
		n5.fx = div_init(p_s4.na, p_s4.den);
		n5.fy = div_init(p_s4.nb, p_s4.den);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= n1;
			p_s2 <= n2;
			p_s3 <= n3;
			p_s4 <= n4;
			p_s5 <= n5;
		end
	end

	// The square root takes one result bit per stage; the foot dividers share its first stages.
	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		pl_t sq_n;
		pl_t sq_p;
		if (k == 0) begin : g_first
			assign sq_p = p_s5;
		end else begin : g_next
			assign sq_p = p_sq_s[k-1];
		end
		always_comb begin
			sq_n = sq_p;
			sq_n.sq = sqrt_step(sq_p.sq, SQ_N - 1 - k);
			if (k < DIV_QW) begin
				sq_n.fx = div_step(sq_p.fx, sq_p.den, DIV_QW - 1 - k);
				sq_n.fy = div_step(sq_p.fy, sq_p.den, DIV_QW - 1 - k);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				p_sq_s[k] <= sq_n;
			end
		end
	end

	// Stage 6: the foot point, and the chord numerators as partial products.
	always_comb begin
		n6 = p_sq_s[SQ_N-1];
		ma6 = mag32(n6.a);
		mb6 = mag32(n6.b);
		fox = div_out(n6.fx, n6.a[31] ^ n6.sneg);
		foy = div_out(n6.fy, n6.b[31] ^ n6.sneg);
		n6.x0 = PT_W'(n6.cx) - PT_W'(fox);
		n6.y0 = PT_W'(n6.cy) - PT_W'(foy);
		n6.ap0 = ma6 * n6.sq.res[31:0];
		n6.ap1 = ma6 * n6.sq.res[63:32];
		n6.bp0 = mb6 * n6.sq.res[31:0];
		n6.bp1 = mb6 * n6.sq.res[63:32];
	end

	// Stage 7: |A|*g and |B|*g.
	always_comb begin
		n7 = p_s6;
		n7.na = {32'b0, p_s6.ap0} + {p_s6.ap1, 32'b0};
		n7.nb = {32'b0, p_s6.bp0} + {p_s6.bp1, 32'b0};
	end

	// Stage 8: the x chord offset scales with B, the y offset with A.
	always_comb begin
		n8 = p_s7;
		n8.hx = div_init(p_s7.nb, p_s7.den);
		n8.hy = div_init(p_s7.na, p_s7.den);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6 <= n6;
			p_s7 <= n7;
			p_s8 <= n8;
		end
	end

	for (genvar k = 0; k < CH_N; k++) begin : g_ch
		pl_t ch_n;
		pl_t ch_p;
		if (k == 0) begin : g_first
			assign ch_p = p_s8;
		end else begin : g_next
			assign ch_p = p_ch_s[k-1];
		end
		always_comb begin
			ch_n = ch_p;
			ch_n.hx = div_step(ch_p.hx, ch_p.den, CH_N - 1 - k);
			ch_n.hy = div_step(ch_p.hy, ch_p.den, CH_N - 1 - k);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				p_ch_s[k] <= ch_n;
			end
		end
	end

	// Stage 9: the two candidate points.
	always_comb begin
		n9 = p_ch_s[CH_N-1];
		ox9 = div_out(n9.hx, n9.b[31]);
		oy9 = div_out(n9.hy, n9.a[31]);
		n9.x1 = n9.x0 + PT_W'(ox9);
		n9.y1 = n9.y0 - PT_W'(oy9);
		n9.x2 = n9.x0 - PT_W'(ox9);
		n9.y2 = n9.y0 + PT_W'(oy9);
	end

	// Stage 10: squared offsets from the reference point.
	always_comb begin
		n10 = p_s9;
		e1x = (PT_W+1)'(p_s9.x1) - (PT_W+1)'(p_s9.rx);
		e1y = (PT_W+1)'(p_s9.y1) - (PT_W+1)'(p_s9.ry);
		e2x = (PT_W+1)'(p_s9.x2) - (PT_W+1)'(p_s9.rx);
		e2y = (PT_W+1)'(p_s9.y2) - (PT_W+1)'(p_s9.ry);
		m1x = e1x[PT_W] ? PT_W'(-e1x) : PT_W'(e1x);
		m1y = e1y[PT_W] ? PT_W'(-e1y) : PT_W'(e1y);
		m2x = e2x[PT_W] ? PT_W'(-e2x) : PT_W'(e2x);
		m2y = e2y[PT_W] ? PT_W'(-e2y) : PT_W'(e2y);
		n10.q1x = m1x * m1x;
		n10.q1y = m1y * m1y;
		n10.q2x = m2x * m2x;
		n10.q2y = m2y * m2y;
	end

	// Stage 11: squared distances.
	always_comb begin
		n11 = p_s10;
		n11.d1 = {1'b0, p_s10.q1x} + {1'b0, p_s10.q1y};
		n11.d2 = {1'b0, p_s10.q2x} + {1'b0, p_s10.q2y};
	end

	// Stage 12: pick, saturate and present the beat.
	always_comb begin
		first_nearer = p_s11.d1 < p_s11.d2;
		pick1 = (p_s11.near == first_nearer);
		selx = pick1 ? p_s11.x1 : p_s11.x2;
		sely = pick1 ? p_s11.y1 : p_s11.y2;
		if (p_s11.degen) begin
			ox_n = p_s11.cx;
			oy_n = p_s11.cy;
			hit_n = 1'b0;
			deg_n = 1'b1;
		end else if (p_s11.nohit) begin
			ox_n = sat32(p_s11.x0);
			oy_n = sat32(p_s11.y0);
			hit_n = 1'b0;
			deg_n = 1'b0;
		end else begin
			ox_n = sat32(selx);
			oy_n = sat32(sely);
			hit_n = 1'b1;
			deg_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9 <= n9;
			p_s10 <= n10;
			p_s11 <= n11;
			x_s12 <= ox_n;
			y_s12 <= oy_n;
			hit_s12 <= hit_n;
			deg_s12 <= deg_n;
		end
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(intersects && degenerate_line))
		else $error("intersects and degenerate_line both set on one beat");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input accepted while the output beat is held");

	a_foot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5+SQ_N] |-> ((p_s6.x0 - PT_W'(p_s6.cx)) <= 38'sh4_0000_0000
			&& (p_s6.x0 - PT_W'(p_s6.cx)) >= -38'sh4_0000_0000))
		else $error("foot point offset beyond its clamp");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the line and circle intersection selector.
module tb_top;

	typedef struct {
		logic signed [31:0] a, b, c, cx, cy, rx, ry;
		logic [30:0] r;
		logic near;
	} query_t;

	typedef struct {
		logic signed [31:0] px, py;
		logic hit, degen;
	} answer_t;

	localparam int PIPE_DEPTH = 112;
	localparam int RANDOM_QUERIES = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] line_a = '0, line_b = '0, line_c = '0;
	logic signed [31:0] center_x = '0, center_y = '0, ref_x = '0, ref_y = '0;
	logic [30:0] circle_radius = '0;
	logic prefer_near = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] point_x, point_y;
	logic intersects, degenerate_line;

	query_t pending_queries[$];
	answer_t expected_points[$];
	int idle_phase = 0;
	int mismatches = 0;
	int answers_seen = 0;
	int hits_seen = 0;
	int degens_seen = 0;
	bit in_fired = 1'b0;

	line_circle_intersection_select dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [127:0] umag(logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	// Signed k * m / d truncated toward zero, clamped to magnitude 2^34.
	function automatic logic signed [127:0] clamped_offset(logic signed [127:0] k, logic mneg,
			logic [127:0] m, logic [127:0] d);
		logic [127:0] q;
		logic signed [127:0] v;
		q = (umag(k) * m) / d;
		v = (q > (128'd1 << 34)) ? (128'sd1 <<< 34) : $signed(q);
		return ((k < 0) != mneg) ? -v : v;
	endfunction

	function automatic logic signed [31:0] clip32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [127:0] root_floor(logic [127:0] e);
		logic [127:0] res, t;
		res = '0;
		for (int i = 63; i >= 0; i--) begin
			t = res | (128'd1 << i);
			if (t * t <= e) res = t;
		end
		return res;
	endfunction

	function automatic answer_t chosen_point(query_t q);
		answer_t ans;
		logic signed [127:0] a, b, cx, cy, s, x0, y0, ox, oy, x1, y1, x2, y2;
		logic [127:0] den, smag, rd, s2, g, dist1, dist2;
		logic sneg, first_nearer;
		a = q.a; b = q.b; cx = q.cx; cy = q.cy;
		den = a * a + b * b;
		ans.hit = 1'b0;
		ans.degen = 1'b0;
		if (den == 0) begin
			ans.px = q.cx; ans.py = q.cy; ans.degen = 1'b1;
			return ans;
		end
		s = a * cx + b * cy + ($signed(128'(q.c)) <<< 16);
		sneg = s < 0;
		smag = umag(s);
		x0 = cx - clamped_offset(a, sneg, smag, den);
		y0 = cy - clamped_offset(b, sneg, smag, den);
		rd = 128'(q.r) * 128'(q.r) * den;
		s2 = smag * smag;
		if (s2 > rd) begin
			ans.px = clip32(x0); ans.py = clip32(y0);
			return ans;
		end
		g = root_floor(rd - s2);
		ox = clamped_offset(b, 1'b0, g, den);
		oy = clamped_offset(a, 1'b0, g, den);
		x1 = x0 + ox; y1 = y0 - oy;
		x2 = x0 - ox; y2 = y0 + oy;
		dist1 = umag(x1 - q.rx) * umag(x1 - q.rx) + umag(y1 - q.ry) * umag(y1 - q.ry);
		dist2 = umag(x2 - q.rx) * umag(x2 - q.rx) + umag(y2 - q.ry) * umag(y2 - q.ry);
		first_nearer = dist1 < dist2;
		ans.hit = 1'b1;
		if (q.near == first_nearer) begin
			ans.px = clip32(x1); ans.py = clip32(y1);
		end else begin
			ans.px = clip32(x2); ans.py = clip32(y2);
		end
		return ans;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 8)) - 4 <<< 16;
			1: return $signed($urandom_range(0, 2000)) - 1000 <<< 16;
			2: return $signed($urandom_range(0, 200000)) - 100000;
			3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic query_t random_query();
		query_t q;
		q.a = rand_word(); q.b = rand_word(); q.c = rand_word();
		q.cx = rand_word(); q.cy = rand_word();
		q.rx = rand_word(); q.ry = rand_word();
		case ($urandom_range(0, 3))
			0: q.r = 31'($urandom_range(0, 1000)) << 16;
			1: q.r = 31'($urandom_range(0, 200000));
			default: q.r = 31'($urandom);
		endcase
		q.near = 1'($urandom_range(0, 1));
		// Some lines are moved to pass through the point (1, 0).
		if ($urandom_range(0, 2) != 0 && q.a != 0 && $urandom_range(0, 1)) q.c = -q.a;
		return q;
	endfunction

	function automatic query_t make_query(int a, int b, int c, int cx, int cy, int r,
			int rx, int ry, bit near);
		query_t q;
		q.a = a; q.b = b; q.c = c; q.cx = cx; q.cy = cy;
		q.r = 31'(r); q.rx = rx; q.ry = ry; q.near = near;
		return q;
	endfunction

	function automatic void queue_query(query_t q);
		pending_queries.insert(pending_queries.size(), q);
	endfunction

	function automatic bit idles(int pct_a, int pct_b, bit sender);
		int pct;
		pct = (idle_phase == 0) ? (sender ? pct_a : pct_b) :
			(idle_phase == 1) ? (sender ? pct_b : pct_a) : 0;
		return $urandom_range(0, 99) < pct;
	endfunction

	// Remember whether the beat on the input was taken at this edge.
	always @(posedge clk) begin
		in_fired <= in_valid && !in_stall;
	end

	// Driver: a held beat stays put until taken; new beats go out on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fired) begin
				if (pending_queries.size() != 0 && !idles(34, 65, 1'b1)) begin
					query_t q;
					q = pending_queries.pop_front();
					expected_points.insert(expected_points.size(), chosen_point(q));
					line_a <= q.a; line_b <= q.b; line_c <= q.c;
					center_x <= q.cx; center_y <= q.cy; circle_radius <= q.r;
					ref_x <= q.rx; ref_y <= q.ry; prefer_near <= q.near;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= idles(34, 65, 1'b0);
		end
	end

	// Monitor: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				$display("%0t: result with nothing expected: x=%h y=%h", $time, point_x, point_y);
				mismatches++;
			end else begin
				answer_t e;
				e = expected_points.pop_front();
				answers_seen++;
				hits_seen += e.hit;
				degens_seen += e.degen;
				if (point_x !== e.px || point_y !== e.py || intersects !== e.hit ||
						degenerate_line !== e.degen) begin
					$display("%0t: expected x=%h y=%h hit=%b degen=%b, got x=%h y=%h hit=%b degen=%b",
						$time, e.px, e.py, e.hit, e.degen,
						point_x, point_y, intersects, degenerate_line);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("line_circle_intersection_select verification failed");
		$finish;
	end

	initial begin
		int one;
		one = 1 << 16;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Directed: degenerate line, miss, tangent, two-point picks both ways, equal distances.
		queue_query(make_query(0, 0, 5, 7, -9, one, 0, 0, 1));
		queue_query(make_query(one, 0, -10 * one, 0, 0, one, 0, 0, 1));
		queue_query(make_query(one, 0, -one, 0, 0, one, 0, 0, 1));
		queue_query(make_query(0, one, 0, 0, 0, 2 * one, 3 * one, one, 1));
		queue_query(make_query(0, one, 0, 0, 0, 2 * one, 3 * one, one, 0));
		queue_query(make_query(one, one, 0, 0, 0, 3 * one, 0, 0, 1));
		queue_query(make_query(one, one, 0, 0, 0, 3 * one, 0, 0, 0));
		queue_query(make_query(one, -one, 0, 0, 0, 0, 0, 0, 1));
		queue_query(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
		queue_query(make_query(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 0));
		queue_query(make_query(1, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1));
		queue_query(make_query(32'h80000000, 0, 0, 32'h7fffffff,
			0, 0, 32'h7fffffff, 32'h7fffffff, 0));
		queue_query(make_query(-1, 1, -1, -1, -1, 1, -1, -1, 1));
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			queue_query(random_query());
			if (i == RANDOM_QUERIES / 3 || i == 2 * RANDOM_QUERIES / 3) begin
				wait (pending_queries.size() == 0);
				idle_phase++;
			end
		end
		wait (pending_queries.size() == 0 && !in_valid);
		wait (expected_points.size() == 0);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		$display("Checked %0d results: %0d intersecting, %0d degenerate, rest missing the circle.",
			answers_seen, hits_seen, degens_seen);
		if (mismatches == 0) begin
			$display("line_circle_intersection_select verification clean");
		end else begin
			$display("line_circle_intersection_select verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/lcis_pkg.sv
src/line_circle_intersection_select.sv
sim/tb_top.sv
